[sv/frp_pkg.sv]
// ---------------------------------------------------------------------------
// frp_pkg: shared types and constants of the framed packet receiver
// Request codes, parse steps, register indexes and direction codes.
// ---------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

	typedef enum logic [1:0] {
		REQ_BYTE   = 2'd0,
		REQ_ACK    = 2'd1,
		REQ_READ   = 2'd2,
		REQ_UNUSED = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_HUNT    = 3'd0,
		ST_SYNC2   = 3'd1,
		ST_SYNC3   = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_PAYLOAD = 3'd4
	} parse_step_t;

	typedef enum logic [1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_SYNC_THIRD  = 2'd2,
		REG_NONE        = 2'd3
	} reg_index_t;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;
	localparam logic [7:0] SYNC_THIRD_RST  = 8'h01;

	// first payload byte codes of a direction command
	localparam logic [7:0] CMD_A_NEG = 8'd1;
	localparam logic [7:0] CMD_A_POS = 8'd2;
	localparam logic [7:0] CMD_B_NEG = 8'd4;
	localparam logic [7:0] CMD_B_POS = 8'd8;

	localparam logic signed [1:0] DIR_NEG  = -2'sd1;
	localparam logic signed [1:0] DIR_ZERO = 2'sd0;
	localparam logic signed [1:0] DIR_POS  = 2'sd1;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
	} sync_cfg_t;

endpackage

`default_nettype wire

[sv/frp_cfg.sv]
// ---------------------------------------------------------------------------
// frp_cfg: signature byte registers
// APB-style register file holding the three header signature bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module frp_cfg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [frp_pkg::PADDR_W-1:0]   paddr,
	input  wire  [frp_pkg::PDATA_W-1:0]   pwdata,
	output logic [frp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output frp_pkg::sync_cfg_t            sync_cfg
);
	import frp_pkg::*;

	sync_cfg_t  sync_q;
	reg_index_t reg_idx;
	logic       wr_en;

	assign reg_idx = reg_index_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// write a register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q.first  <= SYNC_FIRST_RST;
			sync_q.second <= SYNC_SECOND_RST;
			sync_q.third  <= SYNC_THIRD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC_FIRST:  sync_q.first  <= pwdata[7:0];
				REG_SYNC_SECOND: sync_q.second <= pwdata[7:0];
				REG_SYNC_THIRD:  sync_q.third  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_SYNC_FIRST:  prdata = {24'd0, sync_q.first};
			REG_SYNC_SECOND: prdata = {24'd0, sync_q.second};
			REG_SYNC_THIRD:  prdata = {24'd0, sync_q.third};
			default:         prdata = '0;
		endcase
	end

	assign sync_cfg = sync_q;

endmodule

`default_nettype wire

[sv/frp_parser.sv]
// ---------------------------------------------------------------------------
// frp_parser: frame parser and command decoder
// Hunts the signature, takes the length and payload bytes, and decodes
// the first payload byte into axis directions or a pending frame.
// ---------------------------------------------------------------------------
`default_nettype none

module frp_parser #(
	parameter int unsigned LENGTH_LIMIT = 10,
	parameter int unsigned LW           = 4
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       accept,
	input  wire  [1:0]                req_type,
	input  wire  [7:0]                rx_byte,
	input  frp_pkg::sync_cfg_t        sync_cfg,
	output logic                      flag,
	output logic [LW-1:0]             frame_len,
	output logic signed [1:0]         dir_a,
	output logic signed [1:0]         dir_b,
	output logic                      wr_en,
	output logic [LW-1:0]             wr_addr,
	output logic [7:0]                wr_data
);
	import frp_pkg::*;

	localparam int unsigned DEPTH = LENGTH_LIMIT - 1;
	localparam logic [8:0]  LIMIT_9 = 9'(LENGTH_LIMIT);
	localparam logic [LW:0] DEPTH_X = (LW + 1)'(DEPTH);

	parse_step_t       step_q, step_d;
	logic [LW-1:0]     count_q, count_d;
	logic [LW-1:0]     len_q, len_d;
	logic              flag_q, flag_d;
	logic signed [1:0] dir_a_q, dir_a_d;
	logic signed [1:0] dir_b_q, dir_b_d;
	logic [7:0]        first_q;
	logic [LW-1:0]     count_inc;
	logic [7:0]        cmd_byte;
	logic              take;
	logic              store_ok;

	assign take      = accept && (req_type_t'(req_type) == REQ_BYTE) && !flag_q;
	assign count_inc = count_q + 1'b1;
	assign store_ok  = (count_q < len_q) && ({1'b0, count_q} < DEPTH_X);
	// a one-byte frame decodes the byte arriving now
	assign cmd_byte  = (count_q == '0) ? rx_byte : first_q;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_HUNT;
			count_q <= '0;
			len_q   <= '0;
			flag_q  <= 1'b0;
			dir_a_q <= DIR_ZERO;
			dir_b_q <= DIR_ZERO;
		end else begin
			step_q  <= step_d;
			count_q <= count_d;
			len_q   <= len_d;
			flag_q  <= flag_d;
			dir_a_q <= dir_a_d;
			dir_b_q <= dir_b_d;
		end
	end

	// keep a copy of the first payload byte for the command decode
	always_ff @(posedge clk) begin
		if (wr_en && (count_q == '0)) begin
			first_q <= rx_byte;
		end
	end

	// advance the parse
	always_comb begin
		step_d  = step_q;
		count_d = count_q;
		len_d   = len_q;
		flag_d  = flag_q;
		dir_a_d = dir_a_q;
		dir_b_d = dir_b_q;
		wr_en   = 1'b0;
		if (accept && (req_type_t'(req_type) == REQ_ACK)) begin
			flag_d = 1'b0;
		end
		if (take) begin
			case (step_q)
				ST_HUNT: begin
					if (rx_byte == sync_cfg.first) step_d = ST_SYNC2;
				end
				ST_SYNC2: begin
					step_d = (rx_byte == sync_cfg.second) ? ST_SYNC3 : ST_HUNT;
				end
				ST_SYNC3: begin
					step_d = (rx_byte == sync_cfg.third) ? ST_LENGTH : ST_HUNT;
				end
				ST_LENGTH: begin
					if ((rx_byte != 8'd0) && ({1'b0, rx_byte} < LIMIT_9)) begin
						len_d   = LW'(rx_byte);
						count_d = '0;
						step_d  = ST_PAYLOAD;
					end else begin
						step_d = ST_HUNT;
					end
				end
				ST_PAYLOAD: begin
					if (store_ok) begin
						wr_en   = 1'b1;
						count_d = count_inc;
						if (count_inc == len_q) begin
							count_d = '0;
							step_d  = ST_HUNT;
							case (cmd_byte)
								CMD_A_NEG: dir_a_d = DIR_NEG;
								CMD_A_POS: dir_a_d = DIR_POS;
								CMD_B_NEG: dir_b_d = DIR_NEG;
								CMD_B_POS: dir_b_d = DIR_POS;
								default:   flag_d  = 1'b1;
							endcase
						end
					end else begin
						count_d = '0;
						step_d  = ST_HUNT;
					end
				end
				default: ;
			endcase
		end
	end

	assign wr_addr   = count_q;
	assign wr_data   = rx_byte;
	assign flag      = flag_q;
	assign frame_len = len_q;
	assign dir_a     = dir_a_q;
	assign dir_b     = dir_b_q;

endmodule

`default_nettype wire

[sv/frp_store.sv]
// ---------------------------------------------------------------------------
// frp_store: payload buffer
// One write port for the parser and one registered read port for software.
// ---------------------------------------------------------------------------
`default_nettype none

module frp_store #(
	parameter int unsigned LENGTH_LIMIT = 10,
	parameter int unsigned LW           = 4
) (
	input  wire              clk,
	input  wire              wr_en,
	input  wire  [LW-1:0]    wr_addr,
	input  wire  [7:0]       wr_data,
	input  wire              rd_load,
	input  wire              rd_en,
	input  wire  [LW-1:0]    rd_addr,
	output logic [7:0]       rd_data_s1
);
	localparam int unsigned DEPTH = LENGTH_LIMIT - 1;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [LW:0] DEPTH_X = (LW + 1)'(DEPTH);

	logic [7:0] mem [DEPTH];
	logic       rd_in_range;

	assign rd_in_range = ({1'b0, rd_addr} < DEPTH_X);

	// write payload byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
	end

	// register read data with the transaction; zero when not a read or out of range
	always_ff @(posedge clk) begin
		if (rd_load) begin
			if (rd_en && rd_in_range) begin
				rd_data_s1 <= mem[rd_addr[AW-1:0]];
			end else begin
				rd_data_s1 <= 8'd0;
			end
		end
	end

endmodule

`default_nettype wire

[sv/frp_outbuf.sv]
// ---------------------------------------------------------------------------
// frp_outbuf: result stage and output register
// Tracks the result stage, moves results to the output register, and
// drives the input ready from the space left in the two.
// ---------------------------------------------------------------------------
`default_nettype none

module frp_outbuf #(
	parameter int unsigned LW = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    accept,
	output logic                   in_ready,
	input  wire                    flag_s1,
	input  wire  [LW-1:0]          len_s1,
	input  wire  [7:0]             rd_data_s1,
	input  wire  signed [1:0]      dir_a_s1,
	input  wire  signed [1:0]      dir_b_s1,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic                   frame_complete,
	output logic [LW-1:0]          payload_length,
	output logic [7:0]             read_data,
	output logic signed [1:0]      axis_a_direction,
	output logic signed [1:0]      axis_b_direction
);
	logic valid_s1;
	logic out_valid_q;
	logic advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// track the result stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// move the result into the output register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			frame_complete   <= flag_s1;
			payload_length   <= len_s1;
			read_data        <= rd_data_s1;
			axis_a_direction <= dir_a_s1;
			axis_b_direction <= dir_b_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[sv/framed_packet_receiver_direction_cmd.sv]
// ---------------------------------------------------------------------------
// framed_packet_receiver_direction_cmd: framed serial packet receiver
// Signature hunt, length and payload capture, direction command decode.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle while in_ready is high, and
// returns one result for each. The parse state is updated in the same cycle
// that a transaction is accepted, and a payload read goes through the buffer's
// registered read port into a result stage, which an output register follows;
// together they let a new transaction in while a result waits. A payload
// entry that was never written since reset reads back as an unspecified
// value. The buffer holds LENGTH_LIMIT-1 bytes.
`default_nettype none

module framed_packet_receiver_direction_cmd #(
	parameter int unsigned LENGTH_LIMIT = 10
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         in_valid,
	output logic                                        in_ready,
	input  wire  [1:0]                                  req_type,
	input  wire  [7:0]                                  rx_byte,
	input  wire  [$clog2(LENGTH_LIMIT)-1:0]             read_index,
	output logic                                        out_valid,
	input  wire                                         out_ready,
	output logic                                        frame_complete,
	output logic [$clog2(LENGTH_LIMIT)-1:0]             payload_length,
	output logic [7:0]                                  read_data,
	output logic signed [1:0]                           axis_a_direction,
	output logic signed [1:0]                           axis_b_direction,
	input  wire                                         psel,
	input  wire                                         penable,
	input  wire                                         pwrite,
	input  wire  [frp_pkg::PADDR_W-1:0]                 paddr,
	input  wire  [frp_pkg::PDATA_W-1:0]                 pwdata,
	output logic [frp_pkg::PDATA_W-1:0]                 prdata,
	output logic                                        pready
);
	import frp_pkg::*;

	localparam int unsigned LW = $clog2(LENGTH_LIMIT);

	sync_cfg_t         sync_cfg;
	logic              accept;
	logic              flag;
	logic [LW-1:0]     frame_len;
	logic signed [1:0] dir_a;
	logic signed [1:0] dir_b;
	logic              wr_en;
	logic [LW-1:0]     wr_addr;
	logic [7:0]        wr_data;
	logic [7:0]        rd_data_s1;
	logic              rd_en;

	assign accept = in_valid && in_ready;
	assign rd_en  = (req_type_t'(req_type) == REQ_READ);

	frp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sync_cfg (sync_cfg)
	);

	frp_parser #(
		.LENGTH_LIMIT (LENGTH_LIMIT),
		.LW           (LW)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.sync_cfg  (sync_cfg),
		.flag      (flag),
		.frame_len (frame_len),
		.dir_a     (dir_a),
		.dir_b     (dir_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	frp_store #(
		.LENGTH_LIMIT (LENGTH_LIMIT),
		.LW           (LW)
	) u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_load    (accept),
		.rd_en      (rd_en),
		.rd_addr    (read_index),
		.rd_data_s1 (rd_data_s1)
	);

	// parser state stays put while the result stage is occupied and the output register is stalled
	frp_outbuf #(
		.LW (LW)
	) u_outbuf (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.in_ready         (in_ready),
		.flag_s1          (flag),
		.len_s1           (frame_len),
		.rd_data_s1       (rd_data_s1),
		.dir_a_s1         (dir_a),
		.dir_b_s1         (dir_b),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.frame_complete   (frame_complete),
		.payload_length   (payload_length),
		.read_data        (read_data),
		.axis_a_direction (axis_a_direction),
		.axis_b_direction (axis_b_direction)
	);

endmodule

`default_nettype wire

[sv/frp_checker.sv]
// ---------------------------------------------------------------------------
// frp_checker: port-level checks of the packet receiver
// Result hold under stall, legal direction codes and length range.
// ---------------------------------------------------------------------------
`default_nettype none

module frp_checker #(
	parameter int unsigned LENGTH_LIMIT = 10
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              out_valid,
	input  wire                              out_ready,
	input  wire                              frame_complete,
	input  wire  [$clog2(LENGTH_LIMIT)-1:0]  payload_length,
	input  wire  [7:0]                       read_data,
	input  wire  [1:0]                       axis_a_direction,
	input  wire  [1:0]                       axis_b_direction
);
	localparam int unsigned LW = $clog2(LENGTH_LIMIT);
	localparam logic [LW:0] LIMIT_X = (LW + 1)'(LENGTH_LIMIT);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_complete)
			&& $stable(payload_length) && $stable(read_data)
			&& $stable(axis_a_direction) && $stable(axis_b_direction))
		else $error("result changed while stalled");

	// directions are only -1, 0 or +1
	a_dir_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (axis_a_direction != 2'b10) && (axis_b_direction != 2'b10))
		else $error("illegal axis direction code");

	// an accepted length stays below the limit
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, payload_length} < LIMIT_X))
		else $error("payload length at or above limit");

endmodule

bind framed_packet_receiver_direction_cmd frp_checker #(
	.LENGTH_LIMIT (LENGTH_LIMIT)
) u_frp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.frame_complete   (frame_complete),
	.payload_length   (payload_length),
	.read_data        (read_data),
	.axis_a_direction (axis_a_direction),
	.axis_b_direction (axis_b_direction)
);

`default_nettype wire

[dv/frp_status_checker.sv]
// ---------------------------------------------------------------------------
// frp_status_checker: result predictor and scoreboard of the packet receiver
// Watches the request, result and register write ports, predicts one status
// per accepted request and compares each returned status field by field.
// ---------------------------------------------------------------------------
module frp_status_checker #(
	parameter int unsigned LENGTH_LIMIT = 10
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_ready,
	input  wire  [1:0]                        req_type,
	input  wire  [7:0]                        rx_byte,
	input  wire  [$clog2(LENGTH_LIMIT)-1:0]   read_index,
	input  wire                               out_valid,
	input  wire                               out_ready,
	input  wire                               frame_complete,
	input  wire  [$clog2(LENGTH_LIMIT)-1:0]   payload_length,
	input  wire  [7:0]                        read_data,
	input  wire  signed [1:0]                 axis_a_direction,
	input  wire  signed [1:0]                 axis_b_direction,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire                               pready,
	input  wire  [frp_pkg::PADDR_W-1:0]       paddr,
	input  wire  [frp_pkg::PDATA_W-1:0]       pwdata,
	output int                                fail_count,
	output int                                outstanding
);
	import frp_pkg::*;

	localparam int unsigned IDX_W       = $clog2(LENGTH_LIMIT);
	localparam int unsigned STORE_DEPTH = LENGTH_LIMIT - 1;

	typedef struct packed {
		logic              frame_complete;
		logic [IDX_W-1:0]  payload_length;
		logic [7:0]        read_data;
		logic signed [1:0] axis_a;
		logic signed [1:0] axis_b;
	} rx_status_t;

	// predicted receiver state
	sync_cfg_t         sync_cfg;
	parse_step_t       hunt_step;
	logic [IDX_W-1:0]  rx_count;
	logic [IDX_W-1:0]  frame_len;
	logic              pending_flag;
	logic [7:0]        payload_mem [STORE_DEPTH];
	logic signed [1:0] dir_a;
	logic signed [1:0] dir_b;

	rx_status_t expected_status_q [$];

	// advance the predicted state by one request and return the status it yields
	function automatic rx_status_t predict_status(input logic [1:0] req, input logic [7:0] b,
		input logic [IDX_W-1:0] idx);
		rx_status_t st;
		st.read_data = 8'h00;
		case (req)
		REQ_BYTE: begin
			// bytes are dropped while a frame waits for acknowledge
			if (!pending_flag) begin
				case (hunt_step)
				ST_HUNT: begin
					if (b == sync_cfg.first)
						hunt_step = ST_SYNC2;
				end
				ST_SYNC2: hunt_step = (b == sync_cfg.second) ? ST_SYNC3 : ST_HUNT;
				ST_SYNC3: hunt_step = (b == sync_cfg.third) ? ST_LENGTH : ST_HUNT;
				ST_LENGTH: begin
					if (b != 8'd0 && b < LENGTH_LIMIT) begin
						frame_len = IDX_W'(b);
						rx_count  = '0;
						hunt_step = ST_PAYLOAD;
					end else
						hunt_step = ST_HUNT;
				end
				ST_PAYLOAD: begin
					if (rx_count < frame_len && rx_count < STORE_DEPTH) begin
						payload_mem[rx_count] = b;
						rx_count = rx_count + 1'b1;
						// frame end: decode the first payload byte
						if (rx_count == frame_len) begin
							rx_count  = '0;
							hunt_step = ST_HUNT;
							case (payload_mem[0])
							CMD_A_NEG: dir_a = DIR_NEG;
							CMD_A_POS: dir_a = DIR_POS;
							CMD_B_NEG: dir_b = DIR_NEG;
							CMD_B_POS: dir_b = DIR_POS;
							default:   pending_flag = 1'b1;
							endcase
						end
					end else begin
						rx_count  = '0;
						hunt_step = ST_HUNT;
					end
				end
				default: ;
				endcase
			end
		end
		REQ_ACK: pending_flag = 1'b0;
		REQ_READ: begin
			if (idx < STORE_DEPTH)
				st.read_data = payload_mem[idx];
		end
		default: ;
		endcase
		st.frame_complete = pending_flag;
		st.payload_length = frame_len;
		st.axis_a         = dir_a;
		st.axis_b         = dir_b;
		return st;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rx_status_t want;
		if (!arst_n) begin
			sync_cfg     = {SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST};
			hunt_step    = ST_HUNT;
			rx_count     = '0;
			frame_len    = '0;
			pending_flag = 1'b0;
			dir_a        = DIR_ZERO;
			dir_b        = DIR_ZERO;
			for (int k = 0; k < STORE_DEPTH; k++)
				payload_mem[k] = 8'h00;
			expected_status_q.delete();
			fail_count   = 0;
			outstanding <= 0;
		end else begin
			// track signature register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[PADDR_W-1:2]))
				REG_SYNC_FIRST:  sync_cfg.first  = pwdata[7:0];
				REG_SYNC_SECOND: sync_cfg.second = pwdata[7:0];
				REG_SYNC_THIRD:  sync_cfg.third  = pwdata[7:0];
				default: ;
				endcase
			end
			// compare the returned status against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_status_q.size() == 0) begin
					$display("%0t: status returned with no request outstanding", $time);
					fail_count++;
				end else begin
					want = expected_status_q.pop_front();
					compare_field("frame_complete", 8'(want.frame_complete), 8'(frame_complete));
					compare_field("payload_length", 8'(want.payload_length), 8'(payload_length));
					compare_field("read_data", want.read_data, read_data);
					compare_field("axis_a_direction", 8'(want.axis_a), 8'(axis_a_direction));
					compare_field("axis_b_direction", 8'(want.axis_b), 8'(axis_b_direction));
				end
			end
			// predict the status of each accepted request
			if (in_valid && in_ready)
				expected_status_q.push_back(predict_status(req_type, rx_byte, read_index));
			outstanding <= expected_status_q.size();
		end
	end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: regression of the framed packet receiver
// Drives directed and random byte streams, acknowledges and payload reads
// through several signature settings and idling profiles; a separate checker
// predicts and compares every status transaction.
// ---------------------------------------------------------------------------
module testbench;
	import frp_pkg::*;

	localparam int unsigned LENGTH_LIMIT = 10;
	localparam int unsigned IDX_W        = $clog2(LENGTH_LIMIT);
	localparam int unsigned STORE_DEPTH  = LENGTH_LIMIT - 1;
	localparam int unsigned PHASES       = 4;
	localparam int unsigned RANDOM_ITEMS = 1050;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [1:0]           req_type   = REQ_BYTE;
	logic [7:0]           rx_byte    = 8'h00;
	logic [IDX_W-1:0]     read_index = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic                 frame_complete;
	logic [IDX_W-1:0]     payload_length;
	logic [7:0]           read_data;
	logic signed [1:0]    axis_a_direction;
	logic signed [1:0]    axis_b_direction;
	logic                 psel       = 1'b0;
	logic                 penable    = 1'b0;
	logic                 pwrite     = 1'b0;
	logic [PADDR_W-1:0]   paddr      = '0;
	logic [PDATA_W-1:0]   pwdata     = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int        fail_count;
	int        outstanding;
	int        send_idle_pct = 0;
	int        stall_pct     = 0;
	int        hold_requests = 0;
	int        hold_served   = 0;
	int        hold_left     = 0;
	int        items_sent    = 0;
	int        cycle_count   = 0;
	sync_cfg_t cfg_now       = {SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST};

	framed_packet_receiver_direction_cmd #(
		.LENGTH_LIMIT(LENGTH_LIMIT)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .rx_byte(rx_byte), .read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_complete(frame_complete), .payload_length(payload_length),
		.read_data(read_data),
		.axis_a_direction(axis_a_direction), .axis_b_direction(axis_b_direction),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	frp_status_checker #(
		.LENGTH_LIMIT(LENGTH_LIMIT)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .rx_byte(rx_byte), .read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_complete(frame_complete), .payload_length(payload_length),
		.read_data(read_data),
		.axis_a_direction(axis_a_direction), .axis_b_direction(axis_b_direction),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("framed_packet_receiver_direction_cmd regression: fail");
			$finish;
		end
	end

	// offer one transaction after a random gap and hold it until accepted
	task automatic send_item(input req_type_t req, input logic [7:0] b,
		input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		rx_byte    <= b;
		read_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(REQ_BYTE, b, IDX_W'($urandom));
	endtask

	// stop offering and wait until every status has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write: setup cycle, access cycle, then idle
	task automatic write_reg(input reg_index_t r, input logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({r, 2'b00});
		pwdata  <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [7:0]       cmd_codes [4];
		sync_cfg_t        next_cfg;
		logic [IDX_W-1:0] len;
		logic [7:0]       b;
		int               phase_start;
		int               quota;
		bit               midpoint_done;
		cmd_codes = '{CMD_A_NEG, CMD_A_POS, CMD_B_NEG, CMD_B_POS};
		quota = RANDOM_ITEMS / PHASES;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: longest frame with a plain first byte fills every buffer entry
		send_byte(cfg_now.first);
		send_byte(cfg_now.second);
		send_byte(cfg_now.third);
		send_byte(8'(STORE_DEPTH));
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(CMD_A_NEG);
		send_byte(CMD_A_POS);
		send_byte(CMD_B_NEG);
		send_byte(CMD_B_POS);
		send_byte(8'hAA);
		// dropped while the frame waits for acknowledge
		send_byte(cfg_now.first);
		// reads: first, last, just out of range, top of the index field
		send_item(REQ_READ, 8'($urandom), '0);
		send_item(REQ_READ, 8'($urandom), IDX_W'(STORE_DEPTH - 1));
		send_item(REQ_READ, 8'($urandom), IDX_W'(STORE_DEPTH));
		send_item(REQ_READ, 8'($urandom), '1);
		// acknowledge, then acknowledge with nothing pending
		send_item(REQ_ACK, 8'($urandom), IDX_W'($urandom));
		send_item(REQ_ACK, 8'($urandom), IDX_W'($urandom));
		send_item(REQ_UNUSED, 8'($urandom), IDX_W'($urandom));
		// zero length restarts the hunt
		send_byte(cfg_now.first);
		send_byte(cfg_now.second);
		send_byte(cfg_now.third);
		send_byte(8'h00);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			// new signature setting while idle
			if (phase != 0) begin
				drain();
				case (phase)
				1:       next_cfg = '0;
				2:       next_cfg = '1;
				default: next_cfg = 24'($urandom);
				endcase
				write_reg(REG_SYNC_FIRST, next_cfg.first);
				write_reg(REG_SYNC_SECOND, next_cfg.second);
				write_reg(REG_SYNC_THIRD, next_cfg.third);
				cfg_now = next_cfg;
			end
			case (phase)
			0:       begin send_idle_pct = 0;  stall_pct = 0;  end
			1:       begin send_idle_pct = 79; stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  stall_pct = 79; end
			default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			phase_start   = items_sent;
			midpoint_done = 1'b0;
			while (items_sent - phase_start < quota) begin
				// halfway: long receiver hold-off, or a full pause of the sender
				if (!midpoint_done && items_sent - phase_start >= quota / 2) begin
					midpoint_done = 1'b1;
					if (phase == 0)
						hold_requests++;
					else if (phase == 1)
						drain();
				end
				case ($urandom_range(99)) inside
				[0:61]: begin
					// well-formed frame, often a direction command
					len = IDX_W'($urandom_range(STORE_DEPTH, 1));
					send_byte(cfg_now.first);
					send_byte(cfg_now.second);
					send_byte(cfg_now.third);
					send_byte(8'(len));
					send_byte(($urandom_range(99) < 60) ? cmd_codes[$urandom_range(3)]
						: 8'($urandom));
					for (int k = 1; k < len; k++)
						send_byte(8'($urandom));
					if ($urandom_range(99) < 65)
						send_item(REQ_ACK, 8'($urandom), IDX_W'($urandom));
				end
				[62:73]: begin
					// broken header
					send_byte(cfg_now.first);
					case ($urandom_range(2))
					0: begin
						// wrong second byte, sometimes equal to the first signature byte
						b = (cfg_now.first != cfg_now.second && $urandom_range(1) == 1)
							? cfg_now.first : 8'($urandom);
						while (b == cfg_now.second)
							b = 8'($urandom);
						send_byte(b);
					end
					1: begin
						send_byte(cfg_now.second);
						b = 8'($urandom);
						while (b == cfg_now.third)
							b = 8'($urandom);
						send_byte(b);
					end
					default: begin
						send_byte(cfg_now.second);
						send_byte(cfg_now.third);
						send_byte(($urandom_range(1) == 1) ? 8'h00
							: 8'($urandom_range(255, LENGTH_LIMIT)));
					end
					endcase
				end
				[74:85]: begin
					repeat ($urandom_range(3, 1))
						send_item(REQ_READ, 8'($urandom), IDX_W'($urandom_range(15)));
				end
				[86:90]: send_item(REQ_ACK, 8'($urandom), IDX_W'($urandom));
				[91:94]: send_item(REQ_UNUSED, 8'($urandom), IDX_W'($urandom));
				default: send_byte(8'($urandom));
				endcase
			end
		end

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("framed_packet_receiver_direction_cmd regression: pass");
		else
			$display("framed_packet_receiver_direction_cmd regression: fail");
		$finish;
	end

endmodule

[framed_packet_receiver_direction_cmd.f]
sv/frp_pkg.sv
sv/frp_cfg.sv
sv/frp_parser.sv
sv/frp_store.sv
sv/frp_outbuf.sv
sv/framed_packet_receiver_direction_cmd.sv
sv/frp_checker.sv
dv/frp_status_checker.sv
dv/testbench.sv
